// ----- design/rfp_pkg.sv -----
// rfp_pkg: constants, types and the keyword matcher of the request frame parser
// used by the channel interfaces and by request_frame_parser; no dependencies
package rfp_pkg;

  localparam int LEN_BITS    = 32;
  localparam int KEYWORD_MAX = 6;
  localparam int KW_NUM      = 13;
  localparam int KW_IDX_W    = $clog2(KEYWORD_MAX);
  localparam int KW_CNT_W    = $clog2(KEYWORD_MAX + 2);

  typedef logic [7:0] byte_t;
  typedef logic [3:0] cmd_t;
  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;
  typedef logic [31:0] len_out_t;
  typedef logic [KEYWORD_MAX-1:0][7:0] kw_buf_t;
  typedef logic [KW_CNT_W-1:0] kw_cnt_t;

  // result kinds
  localparam kind_t KIND_ARG    = 2'd0;
  localparam kind_t KIND_PAY    = 2'd1;
  localparam kind_t KIND_STATUS = 2'd2;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_TRUNC = 2'd1;
  localparam status_t ST_BAD   = 2'd2;

  localparam cmd_t CODE_QUIT = 4'd7;

  localparam byte_t CH_CR   = 8'h0d;
  localparam byte_t CH_LF   = 8'h0a;
  localparam byte_t CH_SP   = 8'h20;
  localparam byte_t CH_ZERO = 8'h30;
  localparam byte_t CH_NINE = 8'h39;

  // keyword text, right aligned, first character at the high end
  localparam logic [63:0] KW_TEXT [KW_NUM] = '{
    64'("APPEND"), 64'("CLOSE"), 64'("LOCK"), 64'("OPEN"), 64'("OPENC"),
    64'("OPENCL"), 64'("OPENL"), 64'("QUIT"), 64'("READ"), 64'("READN"),
    64'("REMOVE"), 64'("UNLOCK"), 64'("WRITE")
  };
  localparam int KW_LEN [KW_NUM] = '{6, 5, 4, 4, 5, 6, 5, 4, 4, 5, 6, 6, 5};

  typedef struct packed {
    logic hit;
    cmd_t code;
  } kw_match_t;

  // one entry of the result buffer: an optional passed byte, then an optional status
  typedef struct packed {
    logic     has_pass;
    kind_t    pass_kind;
    byte_t    pass_byte;
    cmd_t     command;
    len_out_t length;
    logic     has_status;
    status_t  status;
  } res_entry_t;

  function automatic kw_match_t kw_match(kw_buf_t buf_bytes, kw_cnt_t cnt);
    kw_match_t res;
    logic      eq;
    res = '0;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      eq = (KW_LEN[i] <= KEYWORD_MAX) && (int'(cnt) == KW_LEN[i]);
      for (int j = 0; j < KEYWORD_MAX; j++) begin
        if (j < KW_LEN[i]) begin
          if (buf_bytes[j] != KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]) begin
            eq = 1'b0;
          end
        end
      end
      if (eq) begin
        res.hit  = 1'b1;
        res.code = cmd_t'(i);
      end
    end
    return res;
  endfunction

endpackage

// ----- design/rfp_if.sv -----
// rfp_if: valid/ready channels for the request frame parser, input bytes and results
// depends on rfp_pkg
interface rfp_in_if import rfp_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t byte_value;
  logic  end_of_buffer;

  modport source (output valid, byte_value, end_of_buffer, input ready);
  modport sink (input valid, byte_value, end_of_buffer, output ready);
endinterface

interface rfp_out_if import rfp_pkg::*;;
  logic     valid;
  logic     ready;
  kind_t    kind;
  byte_t    out_byte;
  cmd_t     command;
  len_out_t payload_length;
  status_t  status;
  logic     last_of_run;

  modport source (output valid, kind, out_byte, command, payload_length, status,
                  last_of_run, input ready);
  modport sink (input valid, kind, out_byte, command, payload_length, status,
                last_of_run, output ready);
endinterface

// ----- design/request_frame_parser.sv -----
// request_frame_parser: parses one "CMD arg\r\nLEN payload\r\n" frame per buffer
// depends on rfp_pkg and the channel interfaces in rfp_if.sv
//
// The parser takes one byte per clock cycle. Each byte is decoded in the cycle it is
// accepted and its results go into a two-entry result buffer, so the input keeps
// flowing while a result waits for the sink. A byte yields no result, one result
// (a passed argument or payload byte, or the status on the final byte) or two
// (a passed final byte and then the status); the second result is sent as a separate
// output item, so a run of such bytes is limited by the single output port. The
// input stalls only when both buffer entries are occupied.
module request_frame_parser import rfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfp_in_if.sink     in_i,
  rfp_out_if.source  out_o
);

  localparam logic [2:0] PH_CMD  = 3'd0;
  localparam logic [2:0] PH_ARG  = 3'd1;
  localparam logic [2:0] PH_LF1  = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;
  localparam logic [2:0] PH_CR2  = 3'd5;
  localparam logic [2:0] PH_LF2  = 3'd6;
  localparam logic [2:0] PH_DONE = 3'd7;

  localparam int ACC_W = LEN_BITS + 4;
  localparam logic [ACC_W-1:0] LEN_LIMIT = {4'b0, {LEN_BITS{1'b1}}};

  logic [2:0]          phase_q, phase_d;
  kw_buf_t             kw_q, kw_d;
  kw_cnt_t             kw_cnt_q, kw_cnt_d;
  cmd_t                cmd_q, cmd_d;
  logic                arg_seen_q, arg_seen_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic                digits_q, digits_d;
  logic                len_bad_q, len_bad_d;
  logic [LEN_BITS-1:0] remain_q, remain_d;
  logic                err_q, err_d;

  res_entry_t          fifo_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q;
  logic                sub_q;

  logic                in_acc, out_acc, push, pop;
  logic                pass;
  kind_t               pkind;
  byte_t               b;
  kw_match_t           match;
  logic [ACC_W-1:0]    acc_ext, acc_next;
  res_entry_t          new_entry, head;
  logic                show_pass;

  assign b      = in_i.byte_value;
  assign in_acc = in_i.valid && in_i.ready;
  assign match  = kw_match(kw_q, kw_cnt_q);
  assign acc_ext  = ACC_W'(acc_q);
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(b - CH_ZERO);

  // frame decoder
  always_comb begin
    phase_d    = phase_q;
    kw_d       = kw_q;
    kw_cnt_d   = kw_cnt_q;
    cmd_d      = cmd_q;
    arg_seen_d = arg_seen_q;
    acc_d      = acc_q;
    digits_d   = digits_q;
    len_bad_d  = len_bad_q;
    remain_d   = remain_q;
    err_d      = err_q;
    pass       = 1'b0;
    pkind      = KIND_ARG;
    if (!err_q) begin
      unique case (phase_q)
        PH_CMD: begin
          if (b == CH_SP) begin
            if (match.hit) begin
              cmd_d      = match.code;
              arg_seen_d = 1'b0;
              phase_d    = PH_ARG;
            end else begin
              err_d = 1'b1;
            end
          end else begin
            if (int'(kw_cnt_q) < KEYWORD_MAX) begin
              kw_d[kw_cnt_q[KW_IDX_W-1:0]] = b;
            end
            if (int'(kw_cnt_q) <= KEYWORD_MAX) begin
              kw_cnt_d = kw_cnt_q + kw_cnt_t'(1);
            end
          end
        end
        PH_ARG: begin
          if (b == CH_CR) begin
            if (cmd_q == CODE_QUIT && arg_seen_q) begin
              err_d = 1'b1;
            end else begin
              phase_d = PH_LF1;
            end
          end else begin
            arg_seen_d = 1'b1;
            pass       = 1'b1;
            pkind      = KIND_ARG;
          end
        end
        PH_LF1: begin
          if (b == CH_LF) begin
            phase_d = PH_LEN;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_LEN: begin
          if (b == CH_SP) begin
            if (!digits_q || len_bad_q) begin
              err_d = 1'b1;
            end else begin
              remain_d = acc_q;
              phase_d  = (acc_q == '0) ? PH_CR2 : PH_PAY;
            end
          end else if (b >= CH_ZERO && b <= CH_NINE) begin
            if (acc_next > LEN_LIMIT) begin
              len_bad_d = 1'b1;
            end else begin
              acc_d = acc_next[LEN_BITS-1:0];
            end
            digits_d = 1'b1;
          end else begin
            len_bad_d = 1'b1;
          end
        end
        PH_PAY: begin
          pass     = 1'b1;
          pkind    = KIND_PAY;
          remain_d = remain_q - LEN_BITS'(1);
          if (remain_q == LEN_BITS'(1)) begin
            phase_d = PH_CR2;
          end
        end
        PH_CR2: begin
          if (b == CH_CR) begin
            phase_d = PH_LF2;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_LF2: begin
          if (b == CH_LF) begin
            phase_d = PH_DONE;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_DONE: begin
          err_d = 1'b1;
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end

    new_entry.has_pass   = pass;
    new_entry.pass_kind  = pkind;
    new_entry.pass_byte  = b;
    new_entry.command    = cmd_d;
    new_entry.length     = len_out_t'(acc_d);
    new_entry.has_status = in_i.end_of_buffer;
    if (err_d) begin
      new_entry.status = ST_BAD;
    end else if (phase_d == PH_DONE) begin
      new_entry.status = ST_OK;
    end else begin
      new_entry.status = ST_TRUNC;
    end

    // the final byte returns the parser to its idle state
    if (in_i.end_of_buffer) begin
      phase_d    = PH_CMD;
      kw_d       = '0;
      kw_cnt_d   = '0;
      cmd_d      = '0;
      arg_seen_d = 1'b0;
      acc_d      = '0;
      digits_d   = 1'b0;
      len_bad_d  = 1'b0;
      remain_d   = '0;
      err_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CMD;
      kw_q       <= '0;
      kw_cnt_q   <= '0;
      cmd_q      <= '0;
      arg_seen_q <= 1'b0;
      acc_q      <= '0;
      digits_q   <= 1'b0;
      len_bad_q  <= 1'b0;
      remain_q   <= '0;
      err_q      <= 1'b0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      kw_q       <= kw_d;
      kw_cnt_q   <= kw_cnt_d;
      cmd_q      <= cmd_d;
      arg_seen_q <= arg_seen_d;
      acc_q      <= acc_d;
      digits_q   <= digits_d;
      len_bad_q  <= len_bad_d;
      remain_q   <= remain_d;
      err_q      <= err_d;
    end
  end

  // result buffer
  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_acc && (pass || in_i.end_of_buffer);
  assign head       = fifo_q[rd_ptr_q];
  assign show_pass  = head.has_pass && !sub_q;
  assign out_acc    = out_o.valid && out_o.ready;
  assign pop        = out_acc && out_o.last_of_run;

  assign out_o.valid          = (cnt_q != 2'd0);
  assign out_o.kind           = show_pass ? head.pass_kind : KIND_STATUS;
  assign out_o.out_byte       = show_pass ? head.pass_byte : '0;
  assign out_o.command        = head.command;
  assign out_o.payload_length = head.length;
  assign out_o.status         = show_pass ? ST_OK : head.status;
  assign out_o.last_of_run    = show_pass ? !head.has_status : 1'b1;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      sub_q    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
        sub_q    <= 1'b0;
      end else if (out_acc) begin
        sub_q <= 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_status_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_o.last_of_run) |=> (out_o.valid && out_o.kind == KIND_STATUS))
    else $error("passed byte not followed by its status");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && !(in_acc && in_i.end_of_buffer)) |=> err_q)
    else $error("error cleared before end of buffer");

  a_no_pass_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && err_q) |-> !pass)
    else $error("byte passed after a malformed frame");
`endif

endmodule

// ----- test/tb_request_frame_parser.sv -----
// tb_request_frame_parser: random and directed byte streams against a cycle-free
// frame parser model, results checked in order; depends on rfp_pkg, rfp_if.sv
// and request_frame_parser
module tb_request_frame_parser;
  import rfp_pkg::*;

  typedef enum logic [2:0] {
    FR_CMD, FR_ARG, FR_LF1, FR_LEN, FR_PAY, FR_CR2, FR_LF2, FR_DONE
  } frame_phase_e;

  typedef enum int {
    FLT_NONE, FLT_CUT, FLT_BAD_CMD, FLT_LONG_CMD, FLT_QUIT_ARG, FLT_BAD_LF1,
    FLT_NO_LEN, FLT_LEN_CHAR, FLT_LEN_OVF, FLT_LEN_MAX, FLT_BAD_CR2, FLT_BAD_LF2,
    FLT_TRAILING, FLT_FLIP
  } frame_fault_e;

  typedef struct packed {
    byte_t data;
    logic  eob;
  } req_byte_t;

  typedef struct packed {
    kind_t    kind;
    byte_t    data;
    cmd_t     cmd;
    len_out_t len;
    status_t  st;
    logic     last;
  } parse_result_t;

  localparam int ITEMS_PER_STAGE = 225;
  localparam int DRAIN_CYCLES    = 20;

  logic clk_i = 1'b0;
  logic rst_ni;

  rfp_in_if  in_if ();
  rfp_out_if out_if ();

  request_frame_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  string kw_names [13] = '{"APPEND", "CLOSE", "LOCK", "OPEN", "OPENC", "OPENCL",
                           "OPENL", "QUIT", "READ", "READN", "REMOVE", "UNLOCK",
                           "WRITE"};

  req_byte_t     request_bytes [$];
  parse_result_t parse_results_due [$];
  byte_t         frame_buf [$];
  req_byte_t     next_req;
  int            items_queued = 0;
  int            items_taken  = 0;
  int            errors       = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;

  // frame parser model state
  frame_phase_e    fr_phase;
  byte_t           kw_buf [KEYWORD_MAX];
  int              kw_cnt;
  cmd_t            cur_cmd;
  logic            arg_seen;
  longint unsigned len_acc;
  logic            len_digits;
  logic            len_bad;
  longint unsigned pay_left;
  status_t         frame_err;

  task automatic note_error(input string msg);
    if (errors < 50) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_frame();
    fr_phase   = FR_CMD;
    foreach (kw_buf[i]) kw_buf[i] = '0;
    kw_cnt     = 0;
    cur_cmd    = '0;
    arg_seen   = 1'b0;
    len_acc    = 0;
    len_digits = 1'b0;
    len_bad    = 1'b0;
    pay_left   = 0;
    frame_err  = ST_OK;
  endtask

  function automatic int keyword_code();
    logic same;
    for (int i = 0; i < 13; i++) begin
      same = (kw_names[i].len() <= KEYWORD_MAX) && (kw_cnt == kw_names[i].len());
      for (int j = 0; j < kw_names[i].len() && j < KEYWORD_MAX; j++) begin
        if (kw_buf[j] != byte_t'(kw_names[i][j])) same = 1'b0;
      end
      if (same) return i;
    end
    return -1;
  endfunction

  task automatic parse_byte(input byte_t b, input logic eob);
    logic            passed;
    kind_t           pkind;
    int              code;
    longint unsigned limit;
    longint unsigned digit;
    status_t         st;
    passed = 1'b0;
    pkind  = KIND_ARG;
    limit  = (64'd1 << LEN_BITS) - 1;
    if (frame_err == ST_OK) begin
      case (fr_phase)
        FR_CMD: begin
          if (b == CH_SP) begin
            code = keyword_code();
            if (code < 0) begin
              frame_err = ST_BAD;
            end else begin
              cur_cmd  = cmd_t'(code);
              arg_seen = 1'b0;
              fr_phase = FR_ARG;
            end
          end else begin
            if (kw_cnt < KEYWORD_MAX) kw_buf[kw_cnt] = b;
            if (kw_cnt <= KEYWORD_MAX) kw_cnt++;
          end
        end
        FR_ARG: begin
          if (b == CH_CR) begin
            if (cur_cmd == CODE_QUIT && arg_seen) frame_err = ST_BAD;
            else fr_phase = FR_LF1;
          end else begin
            arg_seen = 1'b1;
            passed   = 1'b1;
            pkind    = KIND_ARG;
          end
        end
        FR_LF1: begin
          if (b == CH_LF) fr_phase = FR_LEN;
          else frame_err = ST_BAD;
        end
        FR_LEN: begin
          if (b == CH_SP) begin
            if (!len_digits || len_bad) begin
              frame_err = ST_BAD;
            end else begin
              pay_left = len_acc;
              fr_phase = (pay_left == 0) ? FR_CR2 : FR_PAY;
            end
          end else if (b >= CH_ZERO && b <= CH_NINE) begin
            digit = longint'(b - CH_ZERO);
            if (len_acc > (limit - digit) / 10) len_bad = 1'b1;
            else len_acc = len_acc * 10 + digit;
            len_digits = 1'b1;
          end else begin
            len_bad = 1'b1;
          end
        end
        FR_PAY: begin
          passed = 1'b1;
          pkind  = KIND_PAY;
          pay_left--;
          if (pay_left == 0) fr_phase = FR_CR2;
        end
        FR_CR2: begin
          if (b == CH_CR) fr_phase = FR_LF2;
          else frame_err = ST_BAD;
        end
        FR_LF2: begin
          if (b == CH_LF) fr_phase = FR_DONE;
          else frame_err = ST_BAD;
        end
        default: frame_err = ST_BAD;
      endcase
    end
    if (passed) begin
      parse_results_due.push_back(parse_result_t'{pkind, b, cur_cmd, len_acc[31:0],
                                                  ST_OK, !eob});
    end
    if (eob) begin
      if (frame_err != ST_OK) st = ST_BAD;
      else if (fr_phase == FR_DONE) st = ST_OK;
      else st = ST_TRUNC;
      parse_results_due.push_back(parse_result_t'{KIND_STATUS, 8'h00, cur_cmd,
                                                  len_acc[31:0], st, 1'b1});
      clear_frame();
    end
  endtask

  // driver: next item from the pending queue, held while not accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.byte_value    <= '0;
      in_if.end_of_buffer <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (request_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req             = request_bytes.pop_front();
        in_if.valid         <= 1'b1;
        in_if.byte_value    <= next_req.data;
        in_if.end_of_buffer <= next_req.eob;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor: predicts on accepted input items, then checks accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.byte_value, in_if.end_of_buffer);
        items_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (parse_results_due.size() == 0) begin
          note_error($sformatf("unexpected result kind %0d byte %0h", out_if.kind,
                               out_if.out_byte));
        end else begin
          want = parse_results_due.pop_front();
          if (out_if.kind !== want.kind)
            note_error($sformatf("kind %0d, expected %0d", out_if.kind, want.kind));
          if (out_if.out_byte !== want.data)
            note_error($sformatf("out_byte %0h, expected %0h", out_if.out_byte,
                                 want.data));
          if (out_if.command !== want.cmd)
            note_error($sformatf("command %0d, expected %0d", out_if.command,
                                 want.cmd));
          if (out_if.payload_length !== want.len)
            note_error($sformatf("payload_length %0d, expected %0d",
                                 out_if.payload_length, want.len));
          if (out_if.status !== want.st)
            note_error($sformatf("status %0d, expected %0d", out_if.status, want.st));
          if (out_if.last_of_run !== want.last)
            note_error($sformatf("last_of_run %0b, expected %0b", out_if.last_of_run,
                                 want.last));
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(byte_t'(s[i]));
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      request_bytes.push_back(req_byte_t'{frame_buf[i], i == frame_buf.size() - 1});
      items_queued++;
    end
    frame_buf.delete();
  endtask

  function automatic byte_t rand_byte_not(input byte_t avoid);
    byte_t v;
    do v = byte_t'($urandom_range(0, 255)); while (v == avoid);
    return v;
  endfunction

  task automatic make_random_frame();
    int           sel;
    int           kw;
    int           alen;
    int           plen;
    int           pos;
    int           cut;
    frame_fault_e fault;
    string        digits;
    byte_t        len_field [$];
    byte_t        v;
    sel = $urandom_range(0, 99);
    if (sel >= 94) begin
      // pure noise
      repeat ($urandom_range(1, 8)) frame_buf.push_back(byte_t'($urandom_range(0, 255)));
      send_frame();
      return;
    end
    if (sel < 58) fault = FLT_NONE;
    else if (sel < 72) fault = FLT_CUT;
    else fault = frame_fault_e'($urandom_range(FLT_BAD_CMD, FLT_FLIP));
    kw = (fault == FLT_QUIT_ARG) ? int'(CODE_QUIT) : $urandom_range(0, 12);

    // command word
    if (fault == FLT_BAD_CMD) begin
      if ($urandom_range(0, 1)) begin
        append_text(kw_names[kw]);
        frame_buf[$urandom_range(0, frame_buf.size() - 1)] = rand_byte_not(CH_SP);
      end else begin
        repeat ($urandom_range(0, 6)) frame_buf.push_back(rand_byte_not(CH_SP));
      end
    end else begin
      append_text(kw_names[kw]);
      if (fault == FLT_LONG_CMD)
        repeat ($urandom_range(1, 3)) frame_buf.push_back(byte_t'($urandom_range(65, 90)));
    end
    frame_buf.push_back(CH_SP);

    // argument
    if (fault == FLT_QUIT_ARG) alen = $urandom_range(1, 4);
    else if (kw == int'(CODE_QUIT)) alen = 0;
    else alen = $urandom_range(0, 6);
    repeat (alen) frame_buf.push_back(rand_byte_not(CH_CR));
    frame_buf.push_back(CH_CR);
    frame_buf.push_back((fault == FLT_BAD_LF1) ? rand_byte_not(CH_LF) : CH_LF);

    // length field
    plen = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    case (fault)
      FLT_NO_LEN:  digits = "";
      FLT_LEN_OVF: digits = $urandom_range(0, 1) ? "4294967296" : "99999999999";
      FLT_LEN_MAX: digits = "4294967295";
      default: begin
        digits = $sformatf("%0d", plen);
        if ($urandom_range(0, 4) == 0) digits = {"00", digits};
      end
    endcase
    for (int i = 0; i < digits.len(); i++) len_field.push_back(byte_t'(digits[i]));
    if (fault == FLT_LEN_CHAR) begin
      do v = byte_t'($urandom_range(0, 255));
      while ((v >= CH_ZERO && v <= CH_NINE) || v == CH_SP);
      pos = $urandom_range(0, len_field.size());
      len_field.insert(pos, v);
    end
    foreach (len_field[i]) frame_buf.push_back(len_field[i]);
    frame_buf.push_back(CH_SP);

    // payload and closing bytes
    repeat (plen) frame_buf.push_back(byte_t'($urandom_range(0, 255)));
    if (fault != FLT_LEN_MAX) begin
      frame_buf.push_back((fault == FLT_BAD_CR2) ? rand_byte_not(CH_CR) : CH_CR);
      frame_buf.push_back((fault == FLT_BAD_LF2) ? rand_byte_not(CH_LF) : CH_LF);
    end
    if (fault == FLT_TRAILING)
      repeat ($urandom_range(1, 3)) frame_buf.push_back(byte_t'($urandom_range(0, 255)));
    if (fault == FLT_FLIP)
      frame_buf[$urandom_range(0, frame_buf.size() - 1)] = byte_t'($urandom_range(0, 255));
    if (fault == FLT_CUT) begin
      cut = $urandom_range(0, frame_buf.size() - 2);
      while (frame_buf.size() > cut + 1) void'(frame_buf.pop_back());
    end
    send_frame();
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || parse_results_due.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    int stage_idle [4];
    int stage_stall [4];
    int stage_start;
    stage_idle  = '{0, 52, 0, 36};
    stage_stall = '{0, 0, 52, 36};
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.byte_value    = '0;
    in_if.end_of_buffer = 1'b0;
    out_if.ready        = 1'b0;
    clear_frame();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed frames: full frame with payload, bad command, quit with argument,
    // single-byte buffer
    append_text("WRITE \015\0121 \377\015\012");
    send_frame();
    append_text("\377 ");
    send_frame();
    append_text("QUIT a\015");
    send_frame();
    frame_buf.push_back(8'h00);
    send_frame();

    for (int s = 0; s < 4; s++) begin
      send_idle_pct  = stage_idle[s];
      recv_stall_pct = stage_stall[s];
      stage_start    = items_queued;
      while (items_queued - stage_start < ITEMS_PER_STAGE) make_random_frame();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ERROR: timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
